// ----- sv/pkm_pkg.sv -----
// ----------------------------------------------------------------------------
// pkm_pkg
// Types and constants shared by the packed k-mer minimum block.
// ----------------------------------------------------------------------------
package pkm_pkg;

   localparam longint unsigned MAX_LEN_DEFAULT = 64'd65536;

   localparam int CHAR_WIDTH   = 8;
   localparam int VALUE_WIDTH  = 32;
   localparam int POS_WIDTH    = 16;
   localparam int KLEN_WIDTH   = 5;
   localparam int CSR_IDX_WIDTH = 1;
   localparam int CSR_DATA_WIDTH = 5;

   localparam logic [KLEN_WIDTH-1:0] KLEN_MIN   = 5'd1;
   localparam logic [KLEN_WIDTH-1:0] KLEN_MAX   = 5'd16;
   localparam logic [KLEN_WIDTH-1:0] KLEN_RESET = 5'd16;
   localparam logic [1:0]            COMP_XOR   = 2'd2;

   typedef enum logic [CSR_IDX_WIDTH-1:0] {
      CSR_KMER_LENGTH  = 1'b0,
      CSR_REVERSE_MODE = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [CHAR_WIDTH-1:0] base_char;
      logic                  last_char;
   } req_type;

   typedef struct packed {
      logic [VALUE_WIDTH-1:0] min_value;
      logic [POS_WIDTH-1:0]   min_position;
      logic                   found;
   } rsp_type;

   typedef struct packed {
      logic [KLEN_WIDTH-1:0] kmer_length;
      logic                  reverse_mode;
   } cfg_type;

endpackage

// ----- sv/pkm_scan.sv -----
// ----------------------------------------------------------------------------
// pkm_scan
// Per-string scan state: packed window, character count and running minimum.
// ----------------------------------------------------------------------------
module pkm_scan #(
   parameter longint unsigned MAX_LEN = pkm_pkg::MAX_LEN_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              step,
   input  pkm_pkg::req_type  item,
   input  pkm_pkg::cfg_type  cfg,
   output pkm_pkg::rsp_type  result
);

   localparam logic [pkm_pkg::POS_WIDTH-1:0] COUNT_CAP =
      (MAX_LEN - 64'd1 > 64'd65535) ? 16'hFFFF : 16'(MAX_LEN - 64'd1);

   logic [pkm_pkg::VALUE_WIDTH-1:0] window_ff, window_in;
   logic [pkm_pkg::POS_WIDTH-1:0]   count_ff, count_in;
   logic [pkm_pkg::VALUE_WIDTH-1:0] best_ff, best_in;
   logic [pkm_pkg::POS_WIDTH-1:0]   start_ff, start_in;
   logic                            any_ff, any_in;

   logic [pkm_pkg::KLEN_WIDTH-1:0]  k_eff;
   logic [1:0]                      code;
   logic [5:0]                      k_shift;
   logic [pkm_pkg::VALUE_WIDTH-1:0] mask;
   logic [pkm_pkg::VALUE_WIDTH-1:0] window_new;
   logic [pkm_pkg::POS_WIDTH-1:0]   count_new;
   logic [pkm_pkg::POS_WIDTH-1:0]   k_wide;
   logic                            win_full;
   logic                            take;

   always_comb begin
      if (cfg.kmer_length < pkm_pkg::KLEN_MIN) begin
         k_eff = pkm_pkg::KLEN_MIN;
      end else if (cfg.kmer_length > pkm_pkg::KLEN_MAX) begin
         k_eff = pkm_pkg::KLEN_MAX;
      end else begin
         k_eff = cfg.kmer_length;
      end
   end

   assign code    = item.base_char[2:1];
   assign k_shift = {k_eff, 1'b0};
   assign k_wide  = {{(pkm_pkg::POS_WIDTH-pkm_pkg::KLEN_WIDTH){1'b0}}, k_eff};

   // full width at k of 16, otherwise the low 2k bits
   assign mask = (k_eff >= pkm_pkg::KLEN_MAX) ? '1 : ~({pkm_pkg::VALUE_WIDTH{1'b1}} << k_shift);

   always_comb begin
      if (cfg.reverse_mode) begin
         window_new = (((window_ff & mask) >> 2)
                      | ({30'd0, code ^ pkm_pkg::COMP_XOR} << (k_shift - 6'd2))) & mask;
      end else begin
         window_new = ((window_ff << 2) | {30'd0, code}) & mask;
      end
   end

   assign count_new = (count_ff < COUNT_CAP) ? count_ff + 16'd1 : count_ff;
   assign win_full  = (count_new >= k_wide);
   assign take      = win_full && (window_new < best_ff);

   always_comb begin
      result.min_value    = take ? window_new : best_ff;
      result.min_position = take ? count_new - k_wide : start_ff;
      result.found        = any_ff | win_full;
   end

   always_comb begin
      window_in = window_ff;
      count_in  = count_ff;
      best_in   = best_ff;
      start_in  = start_ff;
      any_in    = any_ff;
      if (step) begin
         if (item.last_char) begin
            window_in = '0;
            count_in  = '0;
            best_in   = '1;
            start_in  = '0;
            any_in    = 1'b0;
         end else begin
            window_in = window_new;
            count_in  = count_new;
            best_in   = result.min_value;
            start_in  = result.min_position;
            any_in    = result.found;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= '0;
         count_ff  <= '0;
         best_ff   <= '1;
         start_ff  <= '0;
         any_ff    <= 1'b0;
      end else begin
         window_ff <= window_in;
         count_ff  <= count_in;
         best_ff   <= best_in;
         start_ff  <= start_in;
         any_ff    <= any_in;
      end
   end

endmodule

// ----- sv/packed_kmer_minimum.sv -----
// ----------------------------------------------------------------------------
// packed_kmer_minimum
// Minimum 2-bit packed k-mer of a character stream, forward or
// reverse-complement, with the start position of its first occurrence.
// ----------------------------------------------------------------------------
// One character is taken per clock cycle while req_stall is low. Each
// character passes an input register and then the window update and
// compare against the running minimum; the character marking the end of a
// string, once out of the input register, loads the result register. A
// waiting result does not block the stream: only a second end-of-string
// character that meets a stalled result holds the input. The kmer_length
// and reverse_mode registers are written through the csr port; the user must
// write them only while the block is idle, and the block does not enforce it.
module packed_kmer_minimum #(
   parameter longint unsigned MAX_LEN = pkm_pkg::MAX_LEN_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  pkm_pkg::req_type                    req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output pkm_pkg::rsp_type                    rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [pkm_pkg::CSR_IDX_WIDTH-1:0]   csr_index,
   input  logic [pkm_pkg::CSR_DATA_WIDTH-1:0]  csr_data
);

   pkm_pkg::cfg_type cfg_ff, cfg_in;
   logic             in_valid_ff, in_valid_in;
   pkm_pkg::req_type in_data_ff, in_data_in;
   logic             out_valid_ff, out_valid_in;
   pkm_pkg::rsp_type out_data_ff, out_data_in;
   pkm_pkg::rsp_type result;
   logic             advance;
   logic             req_take;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (pkm_pkg::csr_index_type'(csr_index))
            pkm_pkg::CSR_KMER_LENGTH:  cfg_in.kmer_length  = csr_data;
            pkm_pkg::CSR_REVERSE_MODE: cfg_in.reverse_mode = csr_data[0];
            default:                   cfg_in = cfg_ff;
         endcase
      end
   end

   // an end-of-string item needs the result slot free or draining
   assign advance   = in_valid_ff && (!in_data_ff.last_char || !out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_data_in  = in_data_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
         in_data_in  = req_data;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   pkm_scan #(
      .MAX_LEN (MAX_LEN)
   ) u_scan (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .item   (in_data_ff),
      .cfg    (cfg_ff),
      .result (result)
   );

   always_comb begin
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      if (advance && in_data_ff.last_char) begin
         out_valid_in = 1'b1;
         out_data_in  = result;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.kmer_length  <= pkm_pkg::KLEN_RESET;
         cfg_ff.reverse_mode <= 1'b0;
         in_valid_ff         <= 1'b0;
         out_valid_ff        <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_data_ff  <= in_data_in;
      out_data_ff <= out_data_in;
   end

endmodule
